// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WRCSR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WRCSR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/wrcsr_pkg.sv -----
// Types, constants and register codes of the wall-ring cap span rasterizer.
`default_nettype none
package wrcsr_pkg;

   localparam int SEGMENT_MAX = 64;
   localparam int MAX_SIDE_PX = 1024;
   localparam int COL_W       = 10;
   localparam int LEN_W       = 7;
   localparam int SIDE_W      = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_PX   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_PX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_PX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_TILE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_COLOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHADOWS_ON = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd7;

   localparam logic [31:0] COLOR_LIGHT    = 32'hA99478FF;
   localparam logic [31:0] COLOR_DARK     = 32'h74513FFF;
   localparam logic [31:0] COLOR_SPECKLE  = 32'h886044FF;
   localparam logic [31:0] COLOR_FALLBACK = 32'hA78D72FF;
   localparam logic [31:0] COLOR_BASE_RST = 32'hA78D6EFF;

   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;

   localparam logic [17:0] SHADE_MUL   = 18'd965;
   localparam logic [17:0] SHADE_ADD_R = 18'd1995;
   localparam logic [17:0] SHADE_ADD_G = 18'd1505;
   localparam logic [17:0] SHADE_ADD_B = 18'd2100;
   localparam logic [17:0] SHADE_DIV   = 18'd1000;
   localparam logic [28:0] SHADE_RECIP = 29'd1048;

   typedef struct packed {
      logic [SIDE_W-1:0] width_px;
      logic [SIDE_W-1:0] height_px;
      logic [9:0]        border_px;
      logic [12:0]       door_tile;
      logic [31:0]       base_color;
      logic              shadows_on;
      logic [31:0]       origin_x;
      logic [31:0]       origin_y;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] first;
      logic [LEN_W-1:0] count;
   } desc_type;

   typedef struct packed {
      logic             valid;
      logic             flush;
      logic             empty;
      logic [COL_W-1:0] col;
   } tag_type;

   typedef struct packed {
      tag_type     tag;
      logic [31:0] color;
   } pix_type;

   typedef enum logic [1:0] {
      CLS_CLEAR,
      CLS_LIGHT,
      CLS_DARK,
      CLS_INNER
   } cls_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

endpackage
`default_nettype wire

// ----- rtl/core/wrcsr_front.sv -----
// Front stage: accepts a request, clips its column window and registers the descriptor.
`default_nettype none
module wrcsr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [wrcsr_pkg::COL_W-1:0] req_row,
   input  wire logic [wrcsr_pkg::COL_W-1:0] req_col_first,
   input  wire logic [wrcsr_pkg::COL_W:0]   req_col_end,
   input  wire logic                        q_full,
   output logic                             push,
   output wrcsr_pkg::desc_type              push_data
);

   logic                            front_valid_ff;
   logic                            front_valid_in;
   wrcsr_pkg::desc_type             front_desc_ff;
   wrcsr_pkg::desc_type             front_desc_in;
   logic                            accept;
   logic [wrcsr_pkg::COL_W:0]       first_ext;
   logic [wrcsr_pkg::COL_W:0]       end_lim;
   logic [wrcsr_pkg::COL_W:0]       end_cut;

   always_comb begin
      req_stall = front_valid_ff && q_full;
      accept    = req_valid && !req_stall;
      push      = front_valid_ff && !q_full;
      push_data = front_desc_ff;
      front_valid_in = accept || (front_valid_ff && q_full);

      first_ext = {1'b0, req_col_first};
      end_lim   = first_ext + (wrcsr_pkg::COL_W + 1)'(wrcsr_pkg::SEGMENT_MAX);
      end_cut   = (req_col_end < end_lim) ? req_col_end : end_lim;
      front_desc_in.row   = req_row;
      front_desc_in.first = req_col_first;
      if (req_col_end <= first_ext) begin
         front_desc_in.count = '0;
      end else begin
         front_desc_in.count = wrcsr_pkg::LEN_W'(end_cut - first_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_desc_ff <= front_desc_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/wrcsr_queue.sv -----
// Small descriptor queue between the front stage and the pixel engine.
`default_nettype none
module wrcsr_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire wrcsr_pkg::desc_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output wrcsr_pkg::desc_type      pop_data,
   output logic                     empty
);

   wrcsr_pkg::desc_type                 entry_ff [wrcsr_pkg::QUEUE_DEPTH];
   logic [wrcsr_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [wrcsr_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [wrcsr_pkg::QPTR_W:0]          count_ff;

   always_comb begin
      full     = count_ff == (wrcsr_pkg::QPTR_W + 1)'(wrcsr_pkg::QUEUE_DEPTH);
      empty    = count_ff == '0;
      pop_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + wrcsr_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + wrcsr_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (wrcsr_pkg::QPTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (wrcsr_pkg::QPTR_W + 1)'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/wrcsr_back.sv -----
// Back end: column sequencer and six-stage pixel colour pipeline.
`default_nettype none
module wrcsr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wrcsr_pkg::cfg_type  cfg,
   input  wire logic                q_empty,
   input  wire wrcsr_pkg::desc_type q_data,
   output logic                     q_pop,
   input  wire logic                adv,
   output wrcsr_pkg::pix_type       pix
);

   function automatic logic filled(input logic signed [12:0] px,
                                   input logic signed [12:0] py,
                                   input wrcsr_pkg::cfg_type c);
      logic [wrcsr_pkg::SIDE_W-1:0] wu;
      logic [wrcsr_pkg::SIDE_W-1:0] hu;
      logic signed [12:0]           w;
      logic signed [12:0]           h;
      logic signed [12:0]           b;
      logic                         in_rect;
      logic                         door_hit;
      logic                         band;
      wu = (c.width_px > wrcsr_pkg::SIDE_W'(wrcsr_pkg::MAX_SIDE_PX)) ?
           wrcsr_pkg::SIDE_W'(wrcsr_pkg::MAX_SIDE_PX) : c.width_px;
      hu = (c.height_px > wrcsr_pkg::SIDE_W'(wrcsr_pkg::MAX_SIDE_PX)) ?
           wrcsr_pkg::SIDE_W'(wrcsr_pkg::MAX_SIDE_PX) : c.height_px;
      w  = $signed({2'b00, wu});
      h  = $signed({2'b00, hu});
      b  = $signed({3'b000, c.border_px});
      in_rect  = (px >= 13'sd0) && (px < w) && (py >= 13'sd0) && (py < h);
      door_hit = c.door_tile[12] && (px[12:4] == {3'b000, c.door_tile[11:6]}) &&
                 (py[12:4] == {3'b000, c.door_tile[5:0]});
      band     = (px < b) || (px >= w - b) || (py < b) || (py >= h - b);
      return in_rect && !door_hit && band;
   endfunction

   wrcsr_pkg::seq_state_type        state_ff;
   wrcsr_pkg::seq_state_type        state_in;
   logic [wrcsr_pkg::COL_W-1:0]     row_ff;
   logic [wrcsr_pkg::COL_W:0]       col_ff;
   logic [wrcsr_pkg::LEN_W-1:0]     remain_ff;
   logic                            empty_ff;
   logic                            issue;

   wrcsr_pkg::tag_type              s0_tag_in;
   wrcsr_pkg::tag_type              s0_tag_ff;
   wrcsr_pkg::tag_type              s1_tag_ff;
   wrcsr_pkg::tag_type              s2_tag_ff;
   wrcsr_pkg::tag_type              s3_tag_ff;
   wrcsr_pkg::tag_type              s4_tag_ff;
   wrcsr_pkg::tag_type              s5_tag_ff;

   logic signed [12:0]              px;
   logic signed [12:0]              py;
   logic                            f_c, f_l, f_u, f_r, f_d;
   wrcsr_pkg::cls_type              cls_in;
   wrcsr_pkg::cls_type              s0_cls_ff;
   wrcsr_pkg::cls_type              s1_cls_ff;
   logic [31:0]                     hx_in, hy_in;
   logic [31:0]                     hx_ff, hy_ff;

   logic [31:0]                     px_prod_ff, py_prod_ff;

   logic [31:0]                     hs;
   logic [31:0]                     ht;
   logic [7:0]                      digit_sum;
   logic [5:0]                      fold;
   logic                            speckle;
   logic [31:0]                     color_in;
   logic [31:0]                     s2_color_ff;

   logic                            shade_in;
   logic                            s3_shade_ff, s4_shade_ff;
   logic [31:0]                     s3_color_ff, s4_color_ff;
   logic [17:0]                     x_in [3];
   logic [17:0]                     s3_x_ff [3];
   logic [17:0]                     s4_x_ff [3];
   logic [7:0]                      q_est_in [3];
   logic [7:0]                      s4_q_ff [3];
   logic [28:0]                     recip_prod [3];
   logic [17:0]                     rem [3];
   logic [7:0]                      q_fix [3];
   logic [31:0]                     final_in;
   logic [31:0]                     s5_color_ff;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrcsr_pkg::SEQ_IDLE: begin
            if (!q_empty) begin
               state_in = wrcsr_pkg::SEQ_RUN;
            end
         end
         wrcsr_pkg::SEQ_RUN: begin
            if (adv && (remain_ff == '0)) begin
               state_in = wrcsr_pkg::SEQ_IDLE;
            end
         end
         default: state_in = wrcsr_pkg::SEQ_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      q_pop           = 1'b0;
      issue           = 1'b0;
      s0_tag_in.valid = 1'b0;
      case (state_ff)
         wrcsr_pkg::SEQ_IDLE: begin
            q_pop = !q_empty;
         end
         wrcsr_pkg::SEQ_RUN: begin
            issue           = adv;
            s0_tag_in.valid = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      s0_tag_in.flush = remain_ff == '0;
      s0_tag_in.empty = empty_ff;
      s0_tag_in.col   = col_ff[wrcsr_pkg::COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrcsr_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (q_pop) begin
         row_ff    <= q_data.row;
         col_ff    <= {1'b0, q_data.first};
         remain_ff <= q_data.count;
         empty_ff  <= q_data.count == '0;
      end else if (issue && (remain_ff != '0)) begin
         col_ff    <= col_ff + (wrcsr_pkg::COL_W + 1)'(1);
         remain_ff <= remain_ff - wrcsr_pkg::LEN_W'(1);
      end
   end

   // Stage 0: occupancy of the pixel and its four neighbors, hash inputs.
   always_comb begin
      px  = $signed({2'b00, col_ff});
      py  = $signed({3'b000, row_ff});
      f_c = filled(px, py, cfg);
      f_l = filled(px - 13'sd1, py, cfg);
      f_u = filled(px, py - 13'sd1, cfg);
      f_r = filled(px + 13'sd1, py, cfg);
      f_d = filled(px, py + 13'sd1, cfg);
      if (!f_c) begin
         cls_in = wrcsr_pkg::CLS_CLEAR;
      end else if (!f_l || !f_u) begin
         cls_in = wrcsr_pkg::CLS_LIGHT;
      end else if (!f_r || !f_d) begin
         cls_in = wrcsr_pkg::CLS_DARK;
      end else begin
         cls_in = wrcsr_pkg::CLS_INNER;
      end
      hx_in = {21'd0, col_ff} + cfg.origin_x;
      hy_in = {22'd0, row_ff} + cfg.origin_y;
   end

   // Stage 2: hash fold, speckle test modulo 31 and colour choice.
   always_comb begin
      hs = px_prod_ff ^ py_prod_ff;
      ht = hs ^ (hs >> 13);
      digit_sum = {6'd0, ht[31:30]};
      for (int i = 0; i < 6; i++) begin
         digit_sum = digit_sum + {3'd0, ht[5*i +: 5]};
      end
      fold    = {1'b0, digit_sum[4:0]} + {3'd0, digit_sum[7:5]};
      speckle = (fold == 6'd0) || (fold == 6'd31);
      case (s1_cls_ff)
         wrcsr_pkg::CLS_CLEAR: color_in = '0;
         wrcsr_pkg::CLS_LIGHT: color_in = wrcsr_pkg::COLOR_LIGHT;
         wrcsr_pkg::CLS_DARK:  color_in = wrcsr_pkg::COLOR_DARK;
         wrcsr_pkg::CLS_INNER: begin
            if (speckle) begin
               color_in = wrcsr_pkg::COLOR_SPECKLE;
            end else if (cfg.base_color[7:0] == 8'd0) begin
               color_in = wrcsr_pkg::COLOR_FALLBACK;
            end else begin
               color_in = cfg.base_color;
            end
         end
         default: color_in = '0;
      endcase
   end

   // Stages 3 to 5: shade numerator, reciprocal estimate, one-step correction.
   always_comb begin
      shade_in = cfg.shadows_on && (s2_color_ff[7:0] != 8'd0);
      x_in[0] = wrcsr_pkg::SHADE_MUL * {10'd0, s2_color_ff[31:24]} + wrcsr_pkg::SHADE_ADD_R;
      x_in[1] = wrcsr_pkg::SHADE_MUL * {10'd0, s2_color_ff[23:16]} + wrcsr_pkg::SHADE_ADD_G;
      x_in[2] = wrcsr_pkg::SHADE_MUL * {10'd0, s2_color_ff[15:8]} + wrcsr_pkg::SHADE_ADD_B;
      for (int i = 0; i < 3; i++) begin
         recip_prod[i] = {11'd0, s3_x_ff[i]} * wrcsr_pkg::SHADE_RECIP;
         q_est_in[i]   = recip_prod[i][27:20];
         rem[i]        = s4_x_ff[i] - {10'd0, s4_q_ff[i]} * wrcsr_pkg::SHADE_DIV;
         q_fix[i]      = (rem[i] >= wrcsr_pkg::SHADE_DIV) ? s4_q_ff[i] + 8'd1 : s4_q_ff[i];
      end
      if (s4_shade_ff) begin
         final_in = {q_fix[0], q_fix[1], q_fix[2], s4_color_ff[7:0]};
      end else begin
         final_in = s4_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff.valid <= 1'b0;
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
         s3_tag_ff.valid <= 1'b0;
         s4_tag_ff.valid <= 1'b0;
         s5_tag_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_tag_ff <= s0_tag_in;
         s1_tag_ff <= s0_tag_ff;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         s5_tag_ff <= s4_tag_ff;
      end
      if (adv) begin
         s0_cls_ff   <= cls_in;
         hx_ff       <= hx_in;
         hy_ff       <= hy_in;
         s1_cls_ff   <= s0_cls_ff;
         px_prod_ff  <= hx_ff * wrcsr_pkg::HASH_MUL_X;
         py_prod_ff  <= hy_ff * wrcsr_pkg::HASH_MUL_Y;
         s2_color_ff <= color_in;
         s3_shade_ff <= shade_in;
         s3_color_ff <= s2_color_ff;
         s4_shade_ff <= s3_shade_ff;
         s4_color_ff <= s3_color_ff;
         for (int i = 0; i < 3; i++) begin
            s3_x_ff[i] <= x_in[i];
            s4_x_ff[i] <= s3_x_ff[i];
            s4_q_ff[i] <= q_est_in[i];
         end
         s5_color_ff <= final_in;
      end
   end

   always_comb begin
      pix.tag   = s5_tag_ff;
      pix.color = s5_color_ff;
   end

endmodule
`default_nettype wire

// ----- rtl/core/wrcsr_merge.sv -----
// Run merger: joins equal pixel colours into spans and holds the response register.
`default_nettype none
module wrcsr_merge (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire wrcsr_pkg::pix_type           pix,
   output logic                              adv,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [wrcsr_pkg::COL_W-1:0]       rsp_span_start,
   output logic [wrcsr_pkg::LEN_W-1:0]       rsp_span_length,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic [7:0]                        rsp_alpha,
   output logic                              rsp_last
);

   logic                            run_open_ff;
   logic [wrcsr_pkg::COL_W-1:0]     run_start_ff;
   logic [wrcsr_pkg::LEN_W-1:0]     run_len_ff;
   logic [31:0]                     run_color_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [wrcsr_pkg::COL_W-1:0]     start_ff, start_in;
   logic [wrcsr_pkg::LEN_W-1:0]     length_ff, length_in;
   logic [31:0]                     color_ff, color_in;
   logic                            last_ff, last_in;
   logic                            out_free;
   logic                            emit;
   logic                            take;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = pix.tag.valid &&
                 (pix.tag.flush || (run_open_ff && (pix.color != run_color_ff)));
      adv      = !emit || out_free;
      take     = adv && emit;
      rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
      if (pix.tag.flush && pix.tag.empty) begin
         start_in  = pix.tag.col;
         length_in = '0;
         color_in  = '0;
      end else begin
         start_in  = run_start_ff;
         length_in = run_len_ff;
         color_in  = run_color_ff;
      end
      last_in = pix.tag.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         run_open_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv && pix.tag.valid) begin
            run_open_ff <= !pix.tag.flush;
         end
      end
      if (take) begin
         start_ff  <= start_in;
         length_ff <= length_in;
         color_ff  <= color_in;
         last_ff   <= last_in;
      end
      if (adv && pix.tag.valid && !pix.tag.flush) begin
         if (!run_open_ff || (pix.color != run_color_ff)) begin
            run_start_ff <= pix.tag.col;
            run_len_ff   <= wrcsr_pkg::LEN_W'(1);
            run_color_ff <= pix.color;
         end else begin
            run_len_ff <= run_len_ff + wrcsr_pkg::LEN_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid       = rsp_valid_ff;
      rsp_span_start  = start_ff;
      rsp_span_length = length_ff;
      rsp_red         = color_ff[31:24];
      rsp_green       = color_ff[23:16];
      rsp_blue        = color_ff[15:8];
      rsp_alpha       = color_ff[7:0];
      rsp_last        = last_ff;
   end

endmodule
`default_nettype wire

// ----- rtl/core/wall_ring_cap_span_raster.sv -----
// Top level of the wall-ring cap span rasterizer with its configuration registers.
// A request names one row and a column window of the ring; the block answers with
// the spans of equal colour over that window, left to right, the final one flagged
// by rsp_last. A window of n columns (n clipped to 64) is taken from the queue, then
// fed to the colour pipeline one pixel per cycle while the response port does not
// stall: one slot per column and one closing slot, so an empty window gets only the
// closing slot. A stalled response port holds the pipeline.
// A four-entry request queue lets requests be taken while earlier windows are drawn.
// Configuration is to be written by the user through the csr port while no request
// is in flight; the block itself does not enforce this.
`default_nettype none
module wall_ring_cap_span_raster (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [wrcsr_pkg::COL_W-1:0]       req_row,
   input  wire logic [wrcsr_pkg::COL_W-1:0]       req_col_first,
   input  wire logic [wrcsr_pkg::COL_W:0]         req_col_end,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [wrcsr_pkg::COL_W-1:0]            rsp_span_start,
   output logic [wrcsr_pkg::LEN_W-1:0]            rsp_span_length,
   output logic [7:0]                             rsp_red,
   output logic [7:0]                             rsp_green,
   output logic [7:0]                             rsp_blue,
   output logic [7:0]                             rsp_alpha,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wrcsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wrcsr_pkg::CSR_DATA_W-1:0]  csr_data
);

   wrcsr_pkg::cfg_type    cfg_ff;
   wrcsr_pkg::desc_type   push_data;
   wrcsr_pkg::desc_type   pop_data;
   wrcsr_pkg::pix_type    pix;
   logic                  push;
   logic                  pop;
   logic                  q_full;
   logic                  q_empty;
   logic                  adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_px   <= wrcsr_pkg::SIDE_W'(64);
         cfg_ff.height_px  <= wrcsr_pkg::SIDE_W'(64);
         cfg_ff.border_px  <= 10'd8;
         cfg_ff.door_tile  <= '0;
         cfg_ff.base_color <= wrcsr_pkg::COLOR_BASE_RST;
         cfg_ff.shadows_on <= 1'b0;
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wrcsr_pkg::CSR_WIDTH_PX:   cfg_ff.width_px   <= csr_data[10:0];
            wrcsr_pkg::CSR_HEIGHT_PX:  cfg_ff.height_px  <= csr_data[10:0];
            wrcsr_pkg::CSR_BORDER_PX:  cfg_ff.border_px  <= csr_data[9:0];
            wrcsr_pkg::CSR_DOOR_TILE:  cfg_ff.door_tile  <= csr_data[12:0];
            wrcsr_pkg::CSR_BASE_COLOR: cfg_ff.base_color <= csr_data;
            wrcsr_pkg::CSR_SHADOWS_ON: cfg_ff.shadows_on <= csr_data[0];
            wrcsr_pkg::CSR_ORIGIN_X:   cfg_ff.origin_x   <= csr_data;
            wrcsr_pkg::CSR_ORIGIN_Y:   cfg_ff.origin_y   <= csr_data;
            default: cfg_ff.shadows_on <= cfg_ff.shadows_on;
         endcase
      end
   end

   wrcsr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row       (req_row),
      .req_col_first (req_col_first),
      .req_col_end   (req_col_end),
      .q_full        (q_full),
      .push          (push),
      .push_data     (push_data)
   );

   wrcsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   wrcsr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .adv     (adv),
      .pix     (pix)
   );

   wrcsr_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .pix             (pix),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_length (rsp_span_length),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ----- rtl/core/wrcsr_checker.sv -----
// Port-level checker for the rasterizer response channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module wrcsr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [wrcsr_pkg::COL_W-1:0]  rsp_span_start,
   input wire logic [wrcsr_pkg::LEN_W-1:0]  rsp_span_length,
   input wire logic [7:0]                   rsp_red,
   input wire logic [7:0]                   rsp_green,
   input wire logic [7:0]                   rsp_blue,
   input wire logic [7:0]                   rsp_alpha,
   input wire logic                         rsp_last
);

   `WRCSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_span_start) && $stable(rsp_span_length) && $stable(rsp_alpha) && $stable(rsp_last), "stalled response changed")
   `WRCSR_ASSERT_IMP(a_len_max, clock, reset, rsp_valid, rsp_span_length <= wrcsr_pkg::LEN_W'(wrcsr_pkg::SEGMENT_MAX), "span longer than a window")
   `WRCSR_ASSERT_IMP(a_empty_win, clock, reset, rsp_valid && (rsp_span_length == '0), rsp_last && (rsp_alpha == 8'd0) && (rsp_red == 8'd0), "empty window response malformed")
   `WRCSR_ASSERT_IMP(a_clear_rgb, clock, reset, rsp_valid && (rsp_alpha == 8'd0), (rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0), "transparent span carries colour")

endmodule

bind wall_ring_cap_span_raster wrcsr_checker u_wrcsr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_span_start  (rsp_span_start),
   .rsp_span_length (rsp_span_length),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_alpha       (rsp_alpha),
   .rsp_last        (rsp_last)
);
`default_nettype wire
